>>> hw/rtl/slpg_pkg.sv
// Shared types and constants for the status LED pattern generator.
// Used by slpg_div, slpg_dp, slpg_ctrl and the top level; no dependencies.
package slpg_pkg;

  // Shared divider geometry
  localparam int DIV_W  = 48;  // dividend / quotient width
  localparam int DIVR_W = 20;  // divisor / remainder width

  localparam int CFG_W  = 16;
  localparam logic [CFG_W-1:0] HOLD_CUT_RESET = 16'd3000;

  // Phase commands
  localparam logic [1:0] CMD_RESTORE = 2'd1;
  localparam logic [1:0] CMD_NORMAL  = 2'd2;

  // Animation timing in ms
  localparam int BOOT_END_MS     = 3000;
  localparam int BOOT_WHITE_MS   = 2700;
  localparam int STROBE_END_MS   = 400;
  localparam int SCAN_END_MS     = 2000;
  localparam int RESTORE_END_MS  = 2200;

  // Intensities
  localparam logic [7:0] SCAN_LEVEL  = 8'd220;
  localparam logic [7:0] WHITE_LEVEL = 8'd200;
  localparam logic [7:0] FULL_LEVEL  = 8'd255;
  localparam logic [7:0] BLUE_FLOOR  = 8'd13;
  localparam logic [7:0] THROB_BASE  = 8'd150;

  typedef enum logic [1:0] {
    PH_BOOT    = 2'd0,
    PH_RESTORE = 2'd1,
    PH_NORMAL  = 2'd2
  } phase_t;

  // Dividend / divisor selection for the shared divider
  typedef enum logic [3:0] {
    DS_SCAN,
    DS_STROBE,
    DS_INTEN,
    DS_DROP,
    DS_PERIOD,
    DS_M8000,
    DS_BREATH_UP,
    DS_BREATH_DOWN,
    DS_BLUE,
    DS_M2000,
    DS_SWEEP_UP,
    DS_SWEEP_DOWN,
    DS_THROB
  } div_sel_t;

  // Register updates performed by the datapath
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_SET_NORMAL,
    ACT_WHITE,
    ACT_RED,
    ACT_SCAN_COL,
    ACT_STROBE_COL,
    ACT_INTEN,
    ACT_PERIOD,
    ACT_URGENCY_COL,
    ACT_SAVE_REM,
    ACT_SQUARE,
    ACT_BLUE_COL,
    ACT_BLUE_FLAT,
    ACT_GREEN_COL,
    ACT_GREEN_ZERO,
    ACT_THROB_COL
  } act_t;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_t div_sel;
    act_t     act;
    logic     publish;
  } dp_cmd_t;

  typedef struct packed {
    phase_t phase;
    logic   t_ge_boot_end;
    logic   t_ge_boot_white;
    logic   t_lt_strobe;
    logic   t_lt_scan;
    logic   t_lt_white;
    logic   button;
    logic   rx_off;
    logic   scanning;
    logic   failsafe;
    logic   x_lt_300;
    logic   x_lt_1000;
    logic   x_lt_3500;
    logic   x_lt_7000;
    logic   div_done;
    logic   out_busy;
  } dp_status_t;

endpackage

>>> hw/rtl/slpg_div.sv
// Shared restoring divider, two quotient bits per cycle.
// Depends on slpg_pkg for the dividend and divisor widths.
module slpg_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [slpg_pkg::DIV_W-1:0]      dividend,
  input  logic [slpg_pkg::DIVR_W-1:0]     divisor,
  output logic                            done,
  output logic [slpg_pkg::DIV_W-1:0]      quotient,
  output logic [slpg_pkg::DIVR_W-1:0]     remainder
);

  localparam int DW    = slpg_pkg::DIV_W;
  localparam int RW    = slpg_pkg::DIVR_W;
  localparam int STEPS = DW / 2;
  localparam int CW    = $clog2(STEPS);

  logic [DW-1:0] dq;
  logic [RW-1:0] rem;
  logic [RW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          running;

  logic [RW:0]   dext, r1, r2;
  logic          b1, b2;
  logic [RW-1:0] m1, m2;

  always_comb begin
    dext = {1'b0, dvs};
    r1   = {rem, dq[DW-1]};
    b1   = (r1 >= dext);
    m1   = b1 ? RW'(r1 - dext) : r1[RW-1:0];
    r2   = {m1, dq[DW-2]};
    b2   = (r2 >= dext);
    m2   = b2 ? RW'(r2 - dext) : r2[RW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else if (start) begin
      running <= 1'b1;
      done    <= 1'b0;
      cnt     <= '0;
    end else if (running) begin
      cnt <= cnt + 1'b1;
      if (cnt == CW'(STEPS - 1)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (running) begin
      dq  <= {dq[DW-3:0], b1, b2};
      rem <= m2;
    end
  end

  assign quotient  = dq;
  assign remainder = rem;

endmodule

>>> hw/rtl/slpg_dp.sv
// Datapath: input latch, phase/colour state, divider operand select and result register.
// Depends on slpg_pkg and slpg_div.
module slpg_dp #(
  parameter int TIME_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  slpg_pkg::dp_cmd_t              cmd,
  output slpg_pkg::dp_status_t           status,
  input  logic                           cfg_valid,
  input  logic [slpg_pkg::CFG_W-1:0]     cfg_data,
  input  logic [31:0]                    now_ms,
  input  logic [1:0]                     phase_cmd,
  input  logic                           button_down,
  input  logic [31:0]                    held_ms,
  input  logic                           rx_off,
  input  logic                           scanning,
  input  logic                           failsafe,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     red,
  output logic [7:0]                     green,
  output logic [7:0]                     blue,
  output logic [1:0]                     anim_phase
);

  localparam int NOW_W = (TIME_BITS < 32) ? TIME_BITS : 32;
  localparam int DW    = slpg_pkg::DIV_W;
  localparam int RW    = slpg_pkg::DIVR_W;

  slpg_pkg::phase_t       phase, phase_next;
  logic [TIME_BITS-1:0]   phase_start, phase_start_next;
  logic [23:0]            colour;
  logic [slpg_pkg::CFG_W-1:0] hold_cut, cut;

  logic [NOW_W-1:0]       now_r;
  logic [31:0]            held_r;
  logic                   button_r, rx_off_r, scanning_r, failsafe_r;
  logic [TIME_BITS-1:0]   t_r, now_tb;
  logic [RW-1:0]          x_r;
  logic [7:0]             inten_r;
  logic [8:0]             period_r;

  logic [DW-1:0]          div_a, quo;
  logic [RW-1:0]          div_b, rem;
  logic                   div_done;
  logic [11:0]            scan_t;
  logic [12:0]            breath_down;
  logic [9:0]             sweep_down;
  logic [10:0]            throb_p;
  logic [8:0]             period_next;
  logic [7:0]             strobe_v;

  assign cut    = (hold_cut == '0) ? slpg_pkg::CFG_W'(1) : hold_cut;
  assign now_tb = TIME_BITS'(now_ms[NOW_W-1:0]);

  always_comb begin
    phase_next       = phase;
    phase_start_next = phase_start;
    if (phase_cmd == slpg_pkg::CMD_RESTORE) begin
      phase_next       = slpg_pkg::PH_RESTORE;
      phase_start_next = now_tb;
    end else if (phase_cmd == slpg_pkg::CMD_NORMAL) begin
      phase_next = slpg_pkg::PH_NORMAL;
    end
  end

  // Divider operands
  always_comb begin
    scan_t      = (phase == slpg_pkg::PH_RESTORE) ?
                  12'(t_r[11:0] - 12'd400) : t_r[11:0];
    breath_down = 13'(13'd7000 - x_r[12:0]);
    sweep_down  = 10'(10'd1000 - x_r[9:0]);
    throb_p     = (x_r < RW'(1000)) ? x_r[10:0] : 11'(11'd2000 - x_r[10:0]);
    div_a = '0;
    div_b = RW'(1);
    case (cmd.div_sel)
      slpg_pkg::DS_SCAN: begin
        div_a = DW'(scan_t);
        div_b = RW'(180);
      end
      slpg_pkg::DS_STROBE: begin
        div_a = DW'(now_r);
        div_b = RW'(80);
      end
      slpg_pkg::DS_INTEN: begin
        div_a = DW'(held_r) * DW'(255);
        div_b = RW'(cut);
      end
      slpg_pkg::DS_DROP: begin
        div_a = DW'(held_r) * DW'(340);
        div_b = RW'(cut);
      end
      slpg_pkg::DS_PERIOD: begin
        div_a = DW'(now_r);
        div_b = RW'(period_r);
      end
      slpg_pkg::DS_M8000: begin
        div_a = DW'(now_r);
        div_b = RW'(8000);
      end
      slpg_pkg::DS_BREATH_UP: begin
        div_a = DW'({x_r[12:0], 1'b0});
        div_b = RW'(7);
      end
      slpg_pkg::DS_BREATH_DOWN: begin
        div_a = DW'({breath_down, 1'b0});
        div_b = RW'(7);
      end
      slpg_pkg::DS_BLUE: begin
        div_a = DW'(x_r) * DW'(207);
        div_b = RW'(1000000);
      end
      slpg_pkg::DS_M2000: begin
        div_a = DW'(now_r);
        div_b = RW'(2000);
      end
      slpg_pkg::DS_SWEEP_UP: begin
        div_a = DW'(x_r) * DW'(11);
        div_b = RW'(15);
      end
      slpg_pkg::DS_SWEEP_DOWN: begin
        div_a = DW'(sweep_down) * DW'(11);
        div_b = RW'(35);
      end
      slpg_pkg::DS_THROB: begin
        div_a = DW'(throb_p) * DW'(7);
        div_b = RW'(100);
      end
      default: begin
        div_a = '0;
        div_b = RW'(1);
      end
    endcase
  end

  slpg_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (quo),
    .remainder (rem)
  );

  assign period_next = (quo >= DW'(340)) ? 9'd60 : 9'(9'd400 - quo[8:0]);
  assign strobe_v    = (rem >= RW'(40)) ? slpg_pkg::SCAN_LEVEL : 8'd0;

  // Phase, colour and configuration state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= slpg_pkg::PH_BOOT;
      phase_start <= '0;
      colour      <= '0;
      hold_cut    <= slpg_pkg::HOLD_CUT_RESET;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        hold_cut <= cfg_data;
      end
      if (cmd.load) begin
        phase       <= phase_next;
        phase_start <= phase_start_next;
      end
      case (cmd.act)
        slpg_pkg::ACT_SET_NORMAL: phase <= slpg_pkg::PH_NORMAL;
        slpg_pkg::ACT_WHITE:
          colour <= {slpg_pkg::WHITE_LEVEL, slpg_pkg::WHITE_LEVEL, slpg_pkg::WHITE_LEVEL};
        slpg_pkg::ACT_RED: colour <= {slpg_pkg::FULL_LEVEL, 16'd0};
        slpg_pkg::ACT_SCAN_COL: begin
          if (rem < RW'(60)) begin
            colour <= {slpg_pkg::SCAN_LEVEL, 16'd0};
          end else if (rem < RW'(120)) begin
            colour <= {8'd0, slpg_pkg::SCAN_LEVEL, 8'd0};
          end else begin
            colour <= {16'd0, slpg_pkg::SCAN_LEVEL};
          end
        end
        slpg_pkg::ACT_STROBE_COL: colour <= {strobe_v, strobe_v, strobe_v};
        slpg_pkg::ACT_URGENCY_COL:
          colour <= {(rem < RW'(period_r[8:1])) ? inten_r : 8'd0, 16'd0};
        slpg_pkg::ACT_BLUE_COL: colour <= {16'd0, 8'(slpg_pkg::BLUE_FLOOR + quo[7:0])};
        slpg_pkg::ACT_BLUE_FLAT: colour <= {16'd0, slpg_pkg::BLUE_FLOOR};
        slpg_pkg::ACT_GREEN_COL: colour <= {8'd0, quo[7:0], 8'd0};
        slpg_pkg::ACT_GREEN_ZERO: colour <= '0;
        slpg_pkg::ACT_THROB_COL:
          colour <= {8'd0, 8'(slpg_pkg::THROB_BASE + quo[7:0]), 8'd0};
        default: ;
      endcase
      out_valid <= cmd.publish | (out_valid & out_stall);
    end
  end

  // Working registers and result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_r      <= now_ms[NOW_W-1:0];
      held_r     <= held_ms;
      button_r   <= button_down;
      rx_off_r   <= rx_off;
      scanning_r <= scanning;
      failsafe_r <= failsafe;
      t_r        <= now_tb - phase_start_next;
    end
    case (cmd.act)
      slpg_pkg::ACT_INTEN:    inten_r  <= (quo > DW'(255)) ? 8'd255 : quo[7:0];
      slpg_pkg::ACT_PERIOD:   period_r <= period_next;
      slpg_pkg::ACT_SAVE_REM: x_r      <= rem;
      slpg_pkg::ACT_SQUARE:   x_r      <= RW'(quo[9:0]) * RW'(quo[9:0]);
      default: ;
    endcase
    if (cmd.publish) begin
      red        <= colour[23:16];
      green      <= colour[15:8];
      blue       <= colour[7:0];
      anim_phase <= phase;
    end
  end

  always_comb begin
    status.phase           = phase;
    status.t_ge_boot_end   = t_r >= TIME_BITS'(slpg_pkg::BOOT_END_MS);
    status.t_ge_boot_white = t_r >= TIME_BITS'(slpg_pkg::BOOT_WHITE_MS);
    status.t_lt_strobe     = t_r <  TIME_BITS'(slpg_pkg::STROBE_END_MS);
    status.t_lt_scan       = t_r <  TIME_BITS'(slpg_pkg::SCAN_END_MS);
    status.t_lt_white      = t_r <  TIME_BITS'(slpg_pkg::RESTORE_END_MS);
    status.button          = button_r;
    status.rx_off          = rx_off_r;
    status.scanning        = scanning_r;
    status.failsafe        = failsafe_r;
    status.x_lt_300        = x_r < RW'(300);
    status.x_lt_1000       = x_r < RW'(1000);
    status.x_lt_3500       = x_r < RW'(3500);
    status.x_lt_7000       = x_r < RW'(7000);
    status.div_done        = div_done;
    status.out_busy        = out_valid & out_stall;
  end

endmodule

>>> hw/rtl/slpg_ctrl.sv
// Controller: sequences the phase decision and the divider steps for one request.
// Depends on slpg_pkg for the command and status structs.
module slpg_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  slpg_pkg::dp_status_t  status,
  output slpg_pkg::dp_cmd_t     cmd
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_W_SCAN,
    S_W_STROBE,
    S_W_INTEN,
    S_W_DROP,
    S_U_START,
    S_W_UMOD,
    S_W_M8000,
    S_B_SEL,
    S_W_BREATH,
    S_B_START,
    S_W_BLUE,
    S_W_SWEEP_M,
    S_S_SEL,
    S_W_GREEN,
    S_W_THROB_M,
    S_T_START,
    S_W_THROB,
    S_FINISH
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd         = '0;
    cmd.div_sel = slpg_pkg::DS_SCAN;
    cmd.act     = slpg_pkg::ACT_NONE;
    state_next  = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (status.phase)
          slpg_pkg::PH_BOOT: begin
            if (status.t_ge_boot_end) begin
              cmd.act    = slpg_pkg::ACT_SET_NORMAL;
              state_next = S_FINISH;
            end else if (status.t_ge_boot_white) begin
              cmd.act    = slpg_pkg::ACT_WHITE;
              state_next = S_FINISH;
            end else begin
              cmd.div_start = 1'b1;
              cmd.div_sel   = slpg_pkg::DS_SCAN;
              state_next    = S_W_SCAN;
            end
          end
          slpg_pkg::PH_RESTORE: begin
            if (status.t_lt_strobe) begin
              cmd.div_start = 1'b1;
              cmd.div_sel   = slpg_pkg::DS_STROBE;
              state_next    = S_W_STROBE;
            end else if (status.t_lt_scan) begin
              cmd.div_start = 1'b1;
              cmd.div_sel   = slpg_pkg::DS_SCAN;
              state_next    = S_W_SCAN;
            end else if (status.t_lt_white) begin
              cmd.act    = slpg_pkg::ACT_WHITE;
              state_next = S_FINISH;
            end else begin
              cmd.act    = slpg_pkg::ACT_SET_NORMAL;
              state_next = S_FINISH;
            end
          end
          default: begin
            if (status.button && !status.rx_off) begin
              cmd.div_start = 1'b1;
              cmd.div_sel   = slpg_pkg::DS_INTEN;
              state_next    = S_W_INTEN;
            end else if (status.rx_off) begin
              cmd.div_start = 1'b1;
              cmd.div_sel   = slpg_pkg::DS_M8000;
              state_next    = S_W_M8000;
            end else if (status.scanning) begin
              cmd.div_start = 1'b1;
              cmd.div_sel   = slpg_pkg::DS_M2000;
              state_next    = S_W_SWEEP_M;
            end else if (status.failsafe) begin
              cmd.act    = slpg_pkg::ACT_RED;
              state_next = S_FINISH;
            end else begin
              cmd.div_start = 1'b1;
              cmd.div_sel   = slpg_pkg::DS_M2000;
              state_next    = S_W_THROB_M;
            end
          end
        endcase
      end
      S_W_SCAN: begin
        if (status.div_done) begin
          cmd.act    = slpg_pkg::ACT_SCAN_COL;
          state_next = S_FINISH;
        end
      end
      S_W_STROBE: begin
        if (status.div_done) begin
          cmd.act    = slpg_pkg::ACT_STROBE_COL;
          state_next = S_FINISH;
        end
      end
      S_W_INTEN: begin
        if (status.div_done) begin
          cmd.act       = slpg_pkg::ACT_INTEN;
          cmd.div_start = 1'b1;
          cmd.div_sel   = slpg_pkg::DS_DROP;
          state_next    = S_W_DROP;
        end
      end
      S_W_DROP: begin
        if (status.div_done) begin
          cmd.act    = slpg_pkg::ACT_PERIOD;
          state_next = S_U_START;
        end
      end
      S_U_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = slpg_pkg::DS_PERIOD;
        state_next    = S_W_UMOD;
      end
      S_W_UMOD: begin
        if (status.div_done) begin
          cmd.act    = slpg_pkg::ACT_URGENCY_COL;
          state_next = S_FINISH;
        end
      end
      S_W_M8000: begin
        if (status.div_done) begin
          cmd.act    = slpg_pkg::ACT_SAVE_REM;
          state_next = S_B_SEL;
        end
      end
      S_B_SEL: begin
        if (status.x_lt_3500) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = slpg_pkg::DS_BREATH_UP;
          state_next    = S_W_BREATH;
        end else if (status.x_lt_7000) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = slpg_pkg::DS_BREATH_DOWN;
          state_next    = S_W_BREATH;
        end else begin
          cmd.act    = slpg_pkg::ACT_BLUE_FLAT;
          state_next = S_FINISH;
        end
      end
      S_W_BREATH: begin
        if (status.div_done) begin
          cmd.act    = slpg_pkg::ACT_SQUARE;
          state_next = S_B_START;
        end
      end
      S_B_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = slpg_pkg::DS_BLUE;
        state_next    = S_W_BLUE;
      end
      S_W_BLUE: begin
        if (status.div_done) begin
          cmd.act    = slpg_pkg::ACT_BLUE_COL;
          state_next = S_FINISH;
        end
      end
      S_W_SWEEP_M: begin
        if (status.div_done) begin
          cmd.act    = slpg_pkg::ACT_SAVE_REM;
          state_next = S_S_SEL;
        end
      end
      S_S_SEL: begin
        if (status.x_lt_300) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = slpg_pkg::DS_SWEEP_UP;
          state_next    = S_W_GREEN;
        end else if (status.x_lt_1000) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = slpg_pkg::DS_SWEEP_DOWN;
          state_next    = S_W_GREEN;
        end else begin
          cmd.act    = slpg_pkg::ACT_GREEN_ZERO;
          state_next = S_FINISH;
        end
      end
      S_W_GREEN: begin
        if (status.div_done) begin
          cmd.act    = slpg_pkg::ACT_GREEN_COL;
          state_next = S_FINISH;
        end
      end
      S_W_THROB_M: begin
        if (status.div_done) begin
          cmd.act    = slpg_pkg::ACT_SAVE_REM;
          state_next = S_T_START;
        end
      end
      S_T_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = slpg_pkg::DS_THROB;
        state_next    = S_W_THROB;
      end
      S_W_THROB: begin
        if (status.div_done) begin
          cmd.act    = slpg_pkg::ACT_THROB_COL;
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!status.out_busy) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> hw/rtl/status_led_pattern_generator.sv
// Status LED pattern generator; depends on slpg_pkg, slpg_ctrl and slpg_dp.
// Each request runs through dispatch and finish; each divider pass adds a wait state on the
// 48-bit shared divider (2 bits/cycle); the longest path is blue breathing (three passes).
// One request is in flight at a time; the next is taken once the result is in the output
// register, which waits while a stalled result still occupies it.
// Reset (rst, synchronous): boot phase, start time 0, colour cleared, out_valid low, hold cut 3000 ms.
module status_led_pattern_generator #(
  parameter int TIME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] now_ms,
  input  logic [1:0]  phase_cmd,
  input  logic        button_down,
  input  logic [31:0] held_ms,
  input  logic        rx_off,
  input  logic        scanning,
  input  logic        failsafe,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [1:0]  anim_phase,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  slpg_pkg::dp_cmd_t    cmd;
  slpg_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  slpg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  slpg_dp #(
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_valid   (cfg_valid & cfg_ready),
    .cfg_data    (cfg_data),
    .now_ms      (now_ms),
    .phase_cmd   (phase_cmd),
    .button_down (button_down),
    .held_ms     (held_ms),
    .rx_off      (rx_off),
    .scanning    (scanning),
    .failsafe    (failsafe),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .anim_phase  (anim_phase)
  );

endmodule
